FILE: hw/rtl/bmla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmla_pkg;

  localparam int unsigned ActionW   = 2;
  localparam int unsigned RowW      = 9;
  localparam int unsigned ColW      = 10;
  localparam int unsigned PageW     = 3;
  localparam int unsigned CpuAddrW  = 16;
  localparam int unsigned RamAddrW  = 23;
  localparam int unsigned NibW      = 2;
  localparam int unsigned PalW      = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned BankW     = 8;
  localparam int unsigned BankShift = 14;
  localparam int unsigned OffW      = 17;

  // display area of the 256x192 mode, raster coordinates
  localparam int unsigned DispRowLo = 32;
  localparam int unsigned DispRowHi = 224;
  localparam int unsigned DispColLo = 64;
  localparam int unsigned DispColHi = 576;

  localparam int unsigned LoresH = 192;
  localparam int unsigned MidW   = 320;
  localparam int unsigned HiW    = 640;

  localparam int unsigned CpuPageLo = 2;
  localparam int unsigned CpuPageHi = 6;

  typedef enum logic [ActionW-1:0] {
    ActRaster   = 2'd0,
    ActCpuRead  = 2'd1,
    ActCpuWrite = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAccessMode  = 3'd0,
    CfgBankOffset  = 3'd1,
    CfgModeControl = 3'd2,
    CfgActiveBank  = 3'd3,
    CfgShadowBank  = 3'd4,
    CfgClipWindow  = 3'd5,
    CfgScrollX     = 3'd6,
    CfgScrollY     = 3'd7
  } cfg_idx_e;

  typedef enum logic [NibW-1:0] {
    NibByte = 2'd0,
    NibHigh = 2'd1,
    NibLow  = 2'd2
  } nibble_e;

  typedef enum logic [1:0] {
    Res256x192 = 2'd0,
    Res320x256 = 2'd1,
    Res640x256 = 2'd2
  } res_e;

  typedef enum logic [1:0] {
    MapFirst16k  = 2'd0,
    MapSecond16k = 2'd1,
    MapThird16k  = 2'd2,
    MapFirst48k  = 2'd3
  } mapping_e;

  typedef struct packed {
    logic [ActionW-1:0]  act;
    logic                rok;
    logic [1:0]          res;
    logic [9:0]          y_sum;
    logic [10:0]         x_sum;
    logic                cpu_en;
    logic [BankW:0]      cpu_bank;
    logic [CpuAddrW-1:0] cpu_addr;
  } s1_t;

  typedef struct packed {
    logic            en;
    logic [BankW:0]  bank;
    logic [OffW-1:0] off;
    logic [NibW-1:0] nib;
    logic [PalW-1:0] pal;
  } s2_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bmla_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bmla_in_if;
  import bmla_pkg::*;
  logic                valid;
  logic                ready;
  logic [ActionW-1:0]  action;
  logic [RowW-1:0]     raster_row;
  logic [ColW-1:0]     raster_column;
  logic [PageW-1:0]    cpu_page;
  logic [CpuAddrW-1:0] cpu_address;
  modport source (output valid, action, raster_row, raster_column, cpu_page, cpu_address,
                  input ready);
  modport sink (input valid, action, raster_row, raster_column, cpu_page, cpu_address,
                output ready);
endinterface

interface bmla_out_if;
  import bmla_pkg::*;
  logic                valid;
  logic                ready;
  logic                enabled;
  logic [RamAddrW-1:0] ram_address;
  logic [NibW-1:0]     nibble_select;
  logic [PalW-1:0]     palette_base;
  modport source (output valid, enabled, ram_address, nibble_select, palette_base,
                  input ready);
  modport sink (input valid, enabled, ram_address, nibble_select, palette_base,
                output ready);
endinterface

interface bmla_cfg_if;
  import bmla_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bitmap_layer_pixel_and_bank_address.sv
// Address unit of a banked bitmap layer.
// req_i: one word per raster pixel (action 0) or CPU read/write (action 1/2).
//   Raster words give row/column; CPU words give 8K page and bank offset address.
// rsp_o: one word per request: enabled, layer RAM byte address, nibble select
//   and palette base. Words leave in request order.
// cfg_i: register writes (index 0..7), always ready; write only while idle.
// Pipeline: check/scroll-add stage, modulo-reduce stage, bank-add output
//   register. An accepted word goes through s1_q, s2_q and the output register.
// Throughput: one word per cycle unless stalled; longest paths: offset subtract
//   and scroll add of stage 1 and the 11-bit compare/subtract of the reduce stage.
// Stall: while rsp_o holds an untaken word, the whole pipeline holds and
//   req_i.ready is low; nothing is lost or repeated.
// Reset: pipeline empties, registers take their defaults (active bank 8,
//   shadow bank 11, clip window x 0..255 y 0..191, all else 0).
`timescale 1ns / 1ps
`default_nettype none

module bitmap_layer_pixel_and_bank_address (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bmla_in_if.sink   req_i,
  bmla_out_if.source rsp_o,
  bmla_cfg_if.sink  cfg_i
);
  import bmla_pkg::*;

  logic [7:0]  am_q;
  logic [2:0]  bo_q;
  logic [5:0]  mc_q;
  logic [7:0]  ab_q;
  logic [7:0]  sb_q;
  logic [31:0] clip_q;
  logic [8:0]  sx_q;
  logic [7:0]  sy_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      am_q   <= 8'd0;
      bo_q   <= 3'd0;
      mc_q   <= 6'd0;
      ab_q   <= 8'd8;
      sb_q   <= 8'd11;
      clip_q <= 32'hBF00FF00;
      sx_q   <= 9'd0;
      sy_q   <= 8'd0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgAccessMode:  am_q   <= cfg_i.data[7:0];
        CfgBankOffset:  bo_q   <= cfg_i.data[2:0];
        CfgModeControl: mc_q   <= cfg_i.data[5:0];
        CfgActiveBank:  ab_q   <= cfg_i.data[7:0];
        CfgShadowBank:  sb_q   <= cfg_i.data[7:0];
        CfgClipWindow:  clip_q <= cfg_i.data;
        CfgScrollX:     sx_q   <= cfg_i.data[8:0];
        CfgScrollY:     sy_q   <= cfg_i.data[7:0];
      endcase
    end
  end

  logic [7:0] x1, x2, y1, y2;
  assign x1 = clip_q[7:0];
  assign x2 = clip_q[15:8];
  assign y1 = clip_q[23:16];
  assign y2 = clip_q[31:24];

  logic adv;
  logic s1_vq, s2_vq, rsp_vq;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  logic                rsp_en_q;
  logic [RamAddrW-1:0] rsp_addr_q;
  logic [NibW-1:0]     rsp_nib_q;
  logic [PalW-1:0]     rsp_pal_q;

  assign adv         = !rsp_vq || rsp_o.ready;
  assign req_i.ready = adv;

  // stage 1: area / clip checks, scroll sums, CPU gating and bank
  logic [RowW-1:0] row_off;
  logic [ColW-1:0] col_off;
  logic [7:0]      y0, x0;
  logic [8:0]      xh;
  logic            in256, clip256, clip_y, clip320, clip640;
  logic            cpu_flag;
  logic [BankW-1:0] bank8;
  mapping_e        map;

  always_comb begin
    row_off = req_i.raster_row - RowW'(DispRowLo);
    col_off = req_i.raster_column - ColW'(DispColLo);
    y0      = row_off[7:0];
    x0      = col_off[8:1];
    xh      = req_i.raster_column[9:1];
    in256   = (req_i.raster_row >= RowW'(DispRowLo)) && (req_i.raster_row < RowW'(DispRowHi))
           && (req_i.raster_column >= ColW'(DispColLo))
           && (req_i.raster_column < ColW'(DispColHi));
    clip256 = (y0 >= y1) && (y0 <= y2) && (x0 >= x1) && (x0 <= x2);
    clip_y  = (req_i.raster_row >= {1'b0, y1}) && (req_i.raster_row <= {1'b0, y2});
    clip320 = (xh >= {x1, 1'b0}) && (xh <= {x2, 1'b0});
    clip640 = (xh >= {1'b0, x1}) && (xh <= {1'b0, x2});

    s1_d          = '0;
    s1_d.act      = req_i.action;
    s1_d.res      = mc_q[5:4];
    s1_d.cpu_addr = req_i.cpu_address;

    case (res_e'(mc_q[5:4]))
      Res256x192: begin
        s1_d.rok   = am_q[1] && in256 && clip256;
        s1_d.y_sum = 10'(y0) + 10'(sy_q);
        s1_d.x_sum = 11'(x0) + 11'(sx_q);
      end
      Res320x256: begin
        s1_d.rok   = am_q[1] && clip_y && clip320;
        s1_d.y_sum = 10'(req_i.raster_row) + 10'(sy_q);
        s1_d.x_sum = 11'(xh) + 11'(sx_q);
      end
      default: begin
        s1_d.rok   = am_q[1] && clip_y && clip640;
        s1_d.y_sum = 10'(req_i.raster_row) + 10'(sy_q);
        s1_d.x_sum = 11'(req_i.raster_column) + 11'(sx_q);
      end
    endcase

    map      = mapping_e'(am_q[7:6]);
    cpu_flag = (req_i.action == ActCpuWrite) ? am_q[0] : am_q[2];
    s1_d.cpu_en = cpu_flag && ((req_i.cpu_page < PageW'(CpuPageLo))
               || ((req_i.cpu_page < PageW'(CpuPageHi)) && (map == MapFirst48k)));
    bank8 = (am_q[3] ? sb_q : ab_q) + BankW'(bo_q);
    case (map)
      MapSecond16k: s1_d.cpu_bank = {1'b0, bank8} + 9'd1;
      MapThird16k:  s1_d.cpu_bank = {1'b0, bank8} + 9'd2;
      default:      s1_d.cpu_bank = {1'b0, bank8};
    endcase
  end

  // stage 2: modulo reduce, offset within bank, zero disabled pixels
  logic [7:0] ym_lo;
  logic [8:0] xm_mid;
  logic [9:0] xm_hi;

  always_comb begin
    if (s1_q.y_sum >= 10'(2 * LoresH)) begin
      ym_lo = 8'(s1_q.y_sum - 10'(2 * LoresH));
    end else if (s1_q.y_sum >= 10'(LoresH)) begin
      ym_lo = 8'(s1_q.y_sum - 10'(LoresH));
    end else begin
      ym_lo = s1_q.y_sum[7:0];
    end

    if (s1_q.x_sum >= 11'(3 * MidW)) begin
      xm_mid = 9'(s1_q.x_sum - 11'(3 * MidW));
    end else if (s1_q.x_sum >= 11'(2 * MidW)) begin
      xm_mid = 9'(s1_q.x_sum - 11'(2 * MidW));
    end else if (s1_q.x_sum >= 11'(MidW)) begin
      xm_mid = 9'(s1_q.x_sum - 11'(MidW));
    end else begin
      xm_mid = s1_q.x_sum[8:0];
    end

    if (s1_q.x_sum >= 11'(2 * HiW)) begin
      xm_hi = 10'(s1_q.x_sum - 11'(2 * HiW));
    end else if (s1_q.x_sum >= 11'(HiW)) begin
      xm_hi = 10'(s1_q.x_sum - 11'(HiW));
    end else begin
      xm_hi = s1_q.x_sum[9:0];
    end

    s2_d = '0;
    case (s1_q.act)
      ActRaster: begin
        if (s1_q.rok) begin
          s2_d.en   = 1'b1;
          s2_d.bank = {1'b0, ab_q};
          s2_d.pal  = {mc_q[3:0], 4'd0};
          case (res_e'(s1_q.res))
            Res256x192: s2_d.off = {1'b0, ym_lo, s1_q.x_sum[7:0]};
            Res320x256: s2_d.off = {xm_mid, s1_q.y_sum[7:0]};
            default: begin
              s2_d.off = {xm_hi[9:1], s1_q.y_sum[7:0]};
              s2_d.nib = xm_hi[0] ? NibLow : NibHigh;
            end
          endcase
        end
      end
      ActCpuRead, ActCpuWrite: begin
        s2_d.en   = s1_q.cpu_en;
        s2_d.bank = s1_q.cpu_bank;
        s2_d.off  = OffW'(s1_q.cpu_addr);
      end
      default: s2_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq  <= 1'b0;
      s2_vq  <= 1'b0;
      rsp_vq <= 1'b0;
    end else if (adv) begin
      s1_vq  <= req_i.valid;
      s2_vq  <= s1_vq;
      rsp_vq <= s2_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q       <= s1_d;
      s2_q       <= s2_d;
      rsp_en_q   <= s2_q.en;
      rsp_addr_q <= {s2_q.bank, BankShift'(0)} + RamAddrW'(s2_q.off);
      rsp_nib_q  <= s2_q.nib;
      rsp_pal_q  <= s2_q.pal;
    end
  end

  assign rsp_o.valid         = rsp_vq;
  assign rsp_o.enabled       = rsp_en_q;
  assign rsp_o.ram_address   = rsp_addr_q;
  assign rsp_o.nibble_select = rsp_nib_q;
  assign rsp_o.palette_base  = rsp_pal_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> s1_vq)
    else $error("accepted word did not enter stage 1");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vq && !adv |=> s2_vq && $stable(s2_q))
    else $error("stage 2 changed during stall");

  a_nib_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vq |-> rsp_nib_q != 2'd3)
    else $error("illegal nibble select");

  a_nib_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vq && (rsp_nib_q != NibByte) |-> rsp_en_q)
    else $error("nibble select on disabled word");

  a_pal_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vq |-> rsp_pal_q[3:0] == 4'd0)
    else $error("palette base not aligned to 16");

endmodule

`default_nettype wire
